/* hdl/xbr_bfb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package xbr_bfb_pkg;

    // Field widths
    localparam int DEMAND_W   = 16;
    localparam int CAN_ID_W   = 29;
    localparam int PAYLOAD_W  = 32;
    localparam int SRC_ADDR_W = 8;
    localparam int PRIO_W     = 3;
    localparam int PGN_W      = 18;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_W    = 4;

    // Idle frames go out once every this many idle ticks
    localparam int IDLE_REPEAT_TICKS_DEF = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PRIORITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_NUMBER   = 2'd2;

    // Register reset values
    localparam logic [SRC_ADDR_W-1:0] SRC_ADDR_RST       = 8'h27;
    localparam logic [PRIO_W-1:0]     FRAME_PRIORITY_RST = 3'd3;
    localparam logic [PGN_W-1:0]      GROUP_NUMBER_RST   = 18'h0040B;

    // Frame constants
    localparam logic signed [DEMAND_W-1:0] ACTIVE_THRESHOLD = -16'sd2;
    localparam logic signed [DEMAND_W:0]   DEMAND_OFFSET    = 17'sd32126;
    localparam logic [7:0] BYTE2_ACTIVE = 8'hD2;
    localparam logic [7:0] BYTE2_IDLE   = 8'hCC;
    localparam logic [7:0] BYTE_FILL    = 8'hFF;

    typedef struct packed {
        logic [PRIO_W-1:0]     frame_priority;
        logic [PGN_W-1:0]      group_number;
        logic [SRC_ADDR_W-1:0] src_addr;
    } t_cfg;

    // First member lands in the high bits, so can_id sits lowest
    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload_high;
        logic [PAYLOAD_W-1:0] payload_low;
        logic [CAN_ID_W-1:0]  can_id;
    } t_frame;

    localparam int FRAME_W = $bits(t_frame);
    localparam int TDATA_W = ((FRAME_W + 7) / 8) * 8;

endpackage

`default_nettype wire

/* hdl/xbr_bfb_calc.sv */
`timescale 1ns / 1ps
`default_nettype none

module xbr_bfb_calc #(
    parameter int IDLE_REPEAT_TICKS = xbr_bfb_pkg::IDLE_REPEAT_TICKS_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire xbr_bfb_pkg::t_cfg                        i_cfg,
    input  wire logic                                     i_valid,
    output logic                                          o_ready,
    input  wire logic signed [xbr_bfb_pkg::DEMAND_W-1:0]  i_demand,
    output logic                                          o_valid,
    input  wire logic                                     i_ready,
    output xbr_bfb_pkg::t_frame                           o_frame
);
    import xbr_bfb_pkg::*;

    localparam logic [COUNT_W-1:0] REPEAT = COUNT_W'(IDLE_REPEAT_TICKS);

    logic [COUNT_W-1:0]          r_idle_cnt, n_idle_cnt;
    logic [COUNT_W-1:0]          r_msg_cnt, n_msg_cnt;
    logic                        r_valid;
    t_frame                      r_frame, n_frame;
    logic                        w_advance, w_accept, w_active, w_send;
    logic signed [DEMAND_W:0]    w_shifted;
    logic [15:0]                 w_level;
    logic [7:0]                  w_b0, w_b1, w_b2;
    logic [CAN_ID_W-1:0]         w_id;
    logic [COUNT_W-1:0]          w_idle_inc;
    logic [11:0]                 w_sum;
    logic [3:0]                  w_chk;

    // Result register moves when empty or when downstream takes it
    assign w_advance = !r_valid || i_ready;
    assign w_accept  = i_valid && w_advance;
    assign o_ready   = w_advance;
    assign o_valid   = r_valid;
    assign o_frame   = r_frame;

    // Demand level: offset and clamp at zero
    always_comb begin
        w_active  = i_demand < ACTIVE_THRESHOLD;
        w_shifted = (DEMAND_W+1)'(i_demand) + DEMAND_OFFSET;
        w_level   = w_shifted[DEMAND_W] ? 16'h0000 : w_shifted[15:0];
    end

    // Tick bookkeeping and frame bytes
    always_comb begin
        w_idle_inc = r_idle_cnt + 4'd1;
        if (w_active) begin
            n_idle_cnt = '0;
            w_send     = 1'b1;
            w_b0       = w_level[7:0];
            w_b1       = w_level[15:8];
            w_b2       = BYTE2_ACTIVE;
        end else begin
            n_idle_cnt = (w_idle_inc >= REPEAT) ? '0 : w_idle_inc;
            w_send     = (n_idle_cnt == '0);
            w_b0       = BYTE_FILL;
            w_b1       = BYTE_FILL;
            w_b2       = BYTE2_IDLE;
        end
        n_msg_cnt = w_send ? r_msg_cnt + 4'd1 : r_msg_cnt;
    end

    // Identifier, checksum and packing
    always_comb begin
        w_id  = {i_cfg.frame_priority, i_cfg.group_number, i_cfg.src_addr};
        w_sum = 12'(n_msg_cnt) + 12'(w_b0) + 12'(w_b1) + 12'(w_b2) + 12'd1020
              + 12'(w_id[7:0]) + 12'(w_id[15:8]) + 12'(w_id[23:16])
              + 12'(w_id[28:24]);
        w_chk = w_sum[7:4] + w_sum[3:0];
        n_frame.can_id       = w_id;
        n_frame.payload_low  = {BYTE_FILL, w_b2, w_b1, w_b0};
        n_frame.payload_high = {w_chk, n_msg_cnt, BYTE_FILL, BYTE_FILL, BYTE_FILL};
    end

    // Advance state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_cnt <= '0;
            r_msg_cnt  <= '0;
            r_valid    <= 1'b0;
        end else if (w_advance) begin
            r_valid <= w_accept && w_send;
            if (w_accept) begin
                r_idle_cnt <= n_idle_cnt;
                r_msg_cnt  <= n_msg_cnt;
            end
        end
    end

    // Hold the frame payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_frame <= n_frame;
        end
    end

endmodule

`default_nettype wire

/* hdl/xbr_bfb_skid.sv */
`timescale 1ns / 1ps
`default_nettype none

module xbr_bfb_skid (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire xbr_bfb_pkg::t_frame  i_frame,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output xbr_bfb_pkg::t_frame       o_frame
);
    import xbr_bfb_pkg::*;

    logic   r_out_valid, r_buf_valid;
    t_frame r_out_frame, r_buf_frame;
    logic   w_take;

    // Ready depends only on the spare slot, never on i_ready
    assign o_ready = !r_buf_valid;
    assign o_valid = r_out_valid;
    assign o_frame = r_out_frame;
    assign w_take  = r_out_valid && i_ready;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_buf_valid <= 1'b0;
        end else if (r_buf_valid) begin
            if (w_take) begin
                r_buf_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_buf_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Data slots
    always_ff @(posedge i_clk) begin
        if (r_buf_valid) begin
            if (w_take) begin
                r_out_frame <= r_buf_frame;
            end
        end else if (i_valid) begin
            if (!r_out_valid || w_take) begin
                r_out_frame <= i_frame;
            end else begin
                r_buf_frame <= i_frame;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/xbr_brake_frame_builder.sv */
// Extended brake request frame builder.
// Input stream: one demand tick per word on s_axis, tdata[15:0] holds the
// signed acceleration demand (1/2048 m/s^2). Output stream: one CAN frame
// per word on m_axis. A tick with demand below -2 always yields a frame;
// idle ticks yield one frame every IDLE_REPEAT_TICKS idle ticks, others
// yield nothing. Each frame advances the 4-bit message counter in byte 7.
// Configuration: write i_cfg_data to register i_cfg_index when i_cfg_we is
// high (0 source address, 1 priority, 2 group number); only while idle.
// Throughput: one tick per cycle while s_axis_tready is high. An accepted
// tick passes the result register, then the output register, to m_axis_tvalid.
// When m_axis_tready is low the result register and a spare slot absorb
// two frames; s_axis_tready then drops until the output drains, and
// s_axis_tready never depends combinationally on m_axis_tready.
// Reset (synchronous, active low) clears both counters, empties the
// output and restores the configuration registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none

module xbr_brake_frame_builder #(
    parameter int IDLE_REPEAT_TICKS = xbr_bfb_pkg::IDLE_REPEAT_TICKS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [xbr_bfb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [xbr_bfb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // [15:0] accel_demand
    input  wire logic [xbr_bfb_pkg::DEMAND_W-1:0]       s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // [28:0] can_id, [60:29] payload_low, [92:61] payload_high, zero pad
    output logic [xbr_bfb_pkg::TDATA_W-1:0]             m_axis_tdata
);
    import xbr_bfb_pkg::*;

    t_cfg   r_cfg;
    logic   w_calc_valid, w_skid_ready;
    t_frame w_calc_frame, w_out_frame;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_addr       <= SRC_ADDR_RST;
            r_cfg.frame_priority <= FRAME_PRIORITY_RST;
            r_cfg.group_number   <= GROUP_NUMBER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC_ADDR:       r_cfg.src_addr       <= i_cfg_data[SRC_ADDR_W-1:0];
                CFG_FRAME_PRIORITY: r_cfg.frame_priority <= i_cfg_data[PRIO_W-1:0];
                CFG_GROUP_NUMBER:   r_cfg.group_number   <= i_cfg_data[PGN_W-1:0];
                default: ;
            endcase
        end
    end

    xbr_bfb_calc #(
        .IDLE_REPEAT_TICKS (IDLE_REPEAT_TICKS)
    ) u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_demand (s_axis_tdata),
        .o_valid  (w_calc_valid),
        .i_ready  (w_skid_ready),
        .o_frame  (w_calc_frame)
    );

    xbr_bfb_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_calc_valid),
        .o_ready (w_skid_ready),
        .i_frame (w_calc_frame),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_frame (w_out_frame)
    );

    assign m_axis_tdata = {(TDATA_W - FRAME_W)'(0), w_out_frame};

    // An accepted active tick always produces a frame with byte 2 = 0xD2
    a_active_sends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && ($signed(s_axis_tdata) < ACTIVE_THRESHOLD)
        |=> w_calc_valid && (w_calc_frame.payload_low[23:16] == BYTE2_ACTIVE))
        else $error("active tick did not produce a frame");

    // A frame stalled between the stages holds until the output side frees up
    a_calc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_calc_valid && !w_skid_ready |=> w_calc_valid && $stable(w_calc_frame))
        else $error("stalled frame changed before hand-off");

    // Input side only stalls while the inner frame is blocked
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_calc_valid && !w_skid_ready)
        else $error("input stalled without a blocked frame");

    // Output side refuses new frames only while it holds one already
    a_skid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_skid_ready |-> m_axis_tvalid)
        else $error("spare slot full with empty output");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import xbr_bfb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int RANDOM_PER_STEP = 400;
    localparam int PRESSURE_TICKS  = 80;

    // Edge values: saturation, threshold, idle repeat, active clearing the idle count
    localparam logic [DEMAND_W-1:0] EDGE_DEMANDS [20] = '{
        16'h8000, 16'h8281, 16'h8282, 16'h8283, 16'hFFFD,
        16'hFFFE, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h0001,
        16'h0002, 16'h5555, 16'h2AAA, 16'h0064, 16'h0007,
        16'h8001, 16'h7FFF, 16'h0000, 16'hFFFE, 16'hFB2E
    };

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DEMAND_W-1:0]    s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]     m_axis_tdata;

    // Predictor state and its copy of the registers
    logic [SRC_ADDR_W-1:0]  cfg_source   = SRC_ADDR_RST;
    logic [PRIO_W-1:0]      cfg_priority = FRAME_PRIORITY_RST;
    logic [PGN_W-1:0]       cfg_group    = GROUP_NUMBER_RST;
    logic [COUNT_W-1:0]     idle_ticks   = '0;
    logic [COUNT_W-1:0]     msg_count    = '0;

    logic [DEMAND_W-1:0]    demand_queue [$];
    t_frame                 frames_due [$];

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_req      = 0;
    int hold_ack      = 0;
    int hold_left     = 0;
    int mismatch_count = 0;
    int quiet_cycles  = 0;

    xbr_brake_frame_builder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Advance the tick state; return 1 and the frame when this tick sends one
    function automatic bit build_xbr_frame(input logic signed [DEMAND_W-1:0] demand,
                                           output t_frame frm);
        logic signed [DEMAND_W:0] level;
        logic [7:0]               b0, b1, b2, b7;
        logic [COUNT_W-1:0]       nxt;
        logic [CAN_ID_W-1:0]      id;
        int                       sum;
        logic [3:0]               chk;
        bit                       send;
        frm = '0;
        if (demand < ACTIVE_THRESHOLD) begin
            level = demand + DEMAND_OFFSET;
            if (level < 0) begin
                level = '0;
            end
            b0 = level[7:0];
            b1 = level[15:8];
            b2 = BYTE2_ACTIVE;
            idle_ticks = '0;
            send = 1'b1;
        end else begin
            nxt = idle_ticks + 1'b1;
            if (nxt >= IDLE_REPEAT_TICKS_DEF) begin
                nxt = '0;
            end
            idle_ticks = nxt;
            b0 = BYTE_FILL;
            b1 = BYTE_FILL;
            b2 = BYTE2_IDLE;
            send = (nxt == '0);
        end
        if (send) begin
            msg_count = msg_count + 1'b1;
            id = {cfg_priority, cfg_group, cfg_source};
            sum = int'(msg_count) + b0 + b1 + b2 + 4 * int'(BYTE_FILL)
                + id[7:0] + id[15:8] + id[23:16] + id[28:24];
            chk = 4'((sum >> 4) + sum);
            b7 = {chk, msg_count};
            frm.can_id       = id;
            frm.payload_low  = {BYTE_FILL, b2, b1, b0};
            frm.payload_high = {b7, BYTE_FILL, BYTE_FILL, BYTE_FILL};
        end
        return send;
    endfunction

    function automatic logic [DEMAND_W-1:0] random_demand();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            return 16'(-3 - int'($urandom_range(32765)));
        end else if (pick < 85) begin
            return 16'(-2 + int'($urandom_range(32769)));
        end else if (pick < 92) begin
            return 16'(int'($urandom_range(5)) - 5);
        end
        return 16'($urandom);
    endfunction

    // Mix of single ticks and idle runs long enough to hit the repeat
    task automatic queue_random_ticks(input int count);
        int left;
        int run;
        left = count;
        while (left > 0) begin
            if ($urandom_range(3) == 0) begin
                run = $urandom_range(24, 8);
                while (run > 0 && left > 0) begin
                    demand_queue.push_back(16'(-2 + int'($urandom_range(32769))));
                    run--;
                    left--;
                end
            end else begin
                demand_queue.push_back(random_demand());
                left--;
            end
        end
    endtask

    // Wait until every word is taken and every frame has come, then let the pipe empty
    task automatic settle_block();
        while (demand_queue.size() != 0 || s_axis_tvalid || frames_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_SRC_ADDR:       cfg_source   = data[SRC_ADDR_W-1:0];
            CFG_FRAME_PRIORITY: cfg_priority = data[PRIO_W-1:0];
            CFG_GROUP_NUMBER:   cfg_group    = data[PGN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_pace(input int snd, input int rcv);
        snd_idle_pct  = snd;
        rcv_stall_pct = rcv;
    endtask

    // Sequence the run
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed edge cases under reset configuration
        foreach (EDGE_DEMANDS[k]) begin
            demand_queue.push_back(EDGE_DEMANDS[k]);
        end
        settle_block();

        // All-zero identifier, no idling
        write_register(CFG_SRC_ADDR, '0);
        write_register(CFG_FRAME_PRIORITY, '0);
        write_register(CFG_GROUP_NUMBER, '0);
        end_writes();
        queue_random_ticks(RANDOM_PER_STEP);
        settle_block();

        // All-ones identifier with oversized data; the spare index must do nothing
        write_register(CFG_SRC_ADDR, '1);
        write_register(CFG_FRAME_PRIORITY, '1);
        write_register(CFG_GROUP_NUMBER, '1);
        write_register(CFG_SPARE_INDEX, 18'h15A5A);
        end_writes();
        set_pace(53, 0);
        queue_random_ticks(RANDOM_PER_STEP);
        settle_block();

        // Random identifier, receiver stalling
        write_register(CFG_SRC_ADDR, 18'($urandom));
        write_register(CFG_FRAME_PRIORITY, 18'($urandom));
        write_register(CFG_GROUP_NUMBER, 18'($urandom));
        end_writes();
        set_pace(0, 53);
        queue_random_ticks(RANDOM_PER_STEP);
        settle_block();

        // Random identifier, both sides idling
        write_register(CFG_GROUP_NUMBER, 18'($urandom));
        write_register(CFG_SRC_ADDR, 18'($urandom));
        write_register(CFG_SPARE_INDEX, 18'($urandom));
        write_register(CFG_FRAME_PRIORITY, 18'($urandom));
        end_writes();
        set_pace(13, 13);
        queue_random_ticks(RANDOM_PER_STEP);
        settle_block();

        // Long receiver hold while active ticks keep coming
        set_pace(0, 0);
        hold_req = hold_req + 1;
        repeat (PRESSURE_TICKS) begin
            demand_queue.push_back(16'(-3 - int'($urandom_range(32765))));
        end
        settle_block();

        if (mismatch_count == 0) begin
            $display("[xbr_brake_frame_builder] OK");
        end else begin
            $display("[xbr_brake_frame_builder] ERROR");
        end
        $finish;
    end

    // Drive demand words and predict the frame of each accepted one
    always @(posedge i_clk) begin : tick_driver
        t_frame frm;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (build_xbr_frame(s_axis_tdata, frm)) begin
                    frames_due.push_back(frm);
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (demand_queue.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= demand_queue.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check each frame word and pace the output ready
    always @(posedge i_clk) begin : frame_monitor
        t_frame got;
        t_frame want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[FRAME_W-1:0];
                if (frames_due.size() == 0) begin
                    $error("unexpected frame: can_id %h payload_low %h payload_high %h",
                           got.can_id, got.payload_low, got.payload_high);
                    mismatch_count++;
                end else begin
                    want = frames_due.pop_front();
                    if (got.can_id !== want.can_id) begin
                        $error("can_id: expected %h, actual %h", want.can_id, got.can_id);
                        mismatch_count++;
                    end
                    if (got.payload_low !== want.payload_low) begin
                        $error("payload_low: expected %h, actual %h",
                               want.payload_low, got.payload_low);
                        mismatch_count++;
                    end
                    if (got.payload_high !== want.payload_high) begin
                        $error("payload_high: expected %h, actual %h",
                               want.payload_high, got.payload_high);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (hold_ack != hold_req) begin
                m_axis_tready <= 1'b0;
                hold_ack  <= hold_ack + 1;
                hold_left <= HOLD_CYCLES;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // Stop a run where nothing moves on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[xbr_brake_frame_builder] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

/* xbr_brake_frame_builder.f */
hdl/xbr_bfb_pkg.sv
hdl/xbr_bfb_calc.sv
hdl/xbr_bfb_skid.sv
hdl/xbr_brake_frame_builder.sv
tb/sv/testbench.sv
